// ===== rtl/core/pqltd_pkg.sv =====
package pqltd_pkg;

	// default sizes
	localparam int MAX_SUBSPACES_DEF = 32;
	localparam int MAX_CENTROIDS_DEF = 256;
	localparam int MAX_SUB_DIM_DEF   = 16;

	// fixed field widths
	localparam int VAL_W   = 16;
	localparam int TERM_W  = 34;
	localparam int ENTRY_W = 40;
	localparam int SUM_W   = 44;
	localparam int ROOT_W  = 22;
	localparam int CNT_W   = 9;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_QUERY = 2'd1,
		ACT_CODE  = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		MET_EUCLID = 2'd0,
		MET_COSINE = 2'd1,
		MET_DOT    = 2'd2,
		MET_DOT_X  = 2'd3
	} metric_t;

	typedef enum logic [1:0] {
		REG_METRIC    = 2'd0,
		REG_SUB_COUNT = 2'd1,
		REG_CODE_BITS = 2'd2,
		REG_SUB_DIM   = 2'd3
	} cfg_reg_t;

	// root unit handshake
	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

	function automatic logic signed [ENTRY_W-1:0] sat_entry(input logic signed [ENTRY_W:0] v);
		logic signed [ENTRY_W-1:0] r;
		r = v[ENTRY_W-1:0];
		if (v[ENTRY_W] != v[ENTRY_W-1])
			r = v[ENTRY_W] ? {1'b1, {(ENTRY_W-1){1'b0}}} : {1'b0, {(ENTRY_W-1){1'b1}}};
		return r;
	endfunction

	function automatic logic signed [SUM_W-1:0] sat_sum(input logic signed [SUM_W:0] v);
		logic signed [SUM_W-1:0] r;
		r = v[SUM_W-1:0];
		if (v[SUM_W] != v[SUM_W-1])
			r = v[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
		return r;
	endfunction

endpackage

// ===== rtl/core/pqltd_ram.sv =====
module pqltd_ram #(
	parameter int WIDTH = 16,
	parameter int AW    = 8
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [2**AW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/pqltd_isqrt.sv =====
module pqltd_isqrt (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [pqltd_pkg::SUM_W-2:0]         x,
	output pqltd_pkg::sqrt_stat_t               stat,
	output logic [pqltd_pkg::ROOT_W-1:0]        root
);

	localparam int W = pqltd_pkg::SUM_W;

	logic         busy_q;
	logic         done_q;
	logic [W-1:0] rem_q;
	logic [W-1:0] res_q;
	logic [W-1:0] bit_q;
	logic [W-1:0] trial;

	assign trial = res_q + bit_q;

	// one root bit (two radicand bits) per cycle, 22 steps from bit 42 down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
			end else if (busy_q && bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= W'(x);
			res_q <= '0;
			bit_q <= W'(1) << (W - 2);
		end else if (busy_q) begin
			if (rem_q >= trial) begin
				rem_q <= rem_q - trial;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = res_q[pqltd_pkg::ROOT_W-1:0];

endmodule

// ===== rtl/core/pq_lookup_table_distance.sv =====
// Channel   Dir  Payload (low bit first)                               Handshake
// s_axis    in   tuser: action; tdata: subspace, centroid, component,   tvalid/tready
//                value, zero pad to 40 bits
// m_axis    out  tdata: distance, zero pad to 48 bits                   tvalid/tready
// cfg       in   cfg_index (register), cfg_data                        cfg_valid/cfg_ready
//
// Load items and code items that emit nothing do not hold the input; codes
// stream at one per cycle through the table read port until one emits.
// A query item makes one codebook/table read per centroid, then the multiply
// and write-back stages drain before the next item is taken.
// An emitting code holds the input until its distance (cosine/dot) or root
// (euclidean, one root bit per cycle) is registered and m_axis takes the item.
// Reset clears control and score; both memories are undefined until written.
module pq_lookup_table_distance #(
	parameter int MAX_SUBSPACES = pqltd_pkg::MAX_SUBSPACES_DEF,
	parameter int MAX_CENTROIDS = pqltd_pkg::MAX_CENTROIDS_DEF,
	parameter int MAX_SUB_DIM   = pqltd_pkg::MAX_SUB_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // subspace, centroid, component, value, pad
	input  logic [1:0]  s_axis_tuser,   // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // distance, pad
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [5:0]  cfg_data
);

	localparam int SW = (MAX_SUBSPACES > 1) ? $clog2(MAX_SUBSPACES) : 1;
	localparam int CW = $clog2(MAX_CENTROIDS);
	localparam int DW = (MAX_SUB_DIM > 1) ? $clog2(MAX_SUB_DIM) : 1;
	localparam int CB_AW = SW + CW + DW;
	localparam int TB_AW = SW + CW;
	localparam int VW = pqltd_pkg::VAL_W;
	localparam int EW = pqltd_pkg::ENTRY_W;
	localparam int SMW = pqltd_pkg::SUM_W;
	localparam int TW = pqltd_pkg::TERM_W;
	localparam int NW = pqltd_pkg::CNT_W;

	// configuration
	logic [1:0] metric_q;
	logic [5:0] sub_cnt_q;
	logic [3:0] code_bits_q;
	logic [4:0] sub_dim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			metric_q    <= pqltd_pkg::MET_EUCLID;
			sub_cnt_q   <= 6'd32;
			code_bits_q <= 4'd8;
			sub_dim_q   <= 5'd16;
		end else if (cfg_valid) begin
			unique case (pqltd_pkg::cfg_reg_t'(cfg_index))
				pqltd_pkg::REG_METRIC:    metric_q    <= cfg_data[1:0];
				pqltd_pkg::REG_SUB_COUNT: sub_cnt_q   <= cfg_data;
				pqltd_pkg::REG_CODE_BITS: code_bits_q <= cfg_data[3:0];
				pqltd_pkg::REG_SUB_DIM:   sub_dim_q   <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// effective settings
	logic [3:0]    kbits;
	logic [CW-1:0] kmask;
	logic [NW-1:0] n_eff;
	logic [6:0]    d_eff;
	logic          euclid;

	always_comb begin
		kbits = code_bits_q;
		if (kbits < 4'd4) kbits = 4'd4;
		if (kbits > 4'd8) kbits = 4'd8;
		if (int'(kbits) > CW) kbits = 4'(CW);
		kmask = CW'((NW'(1) << kbits) - NW'(1));
		n_eff = NW'(sub_cnt_q);
		if (n_eff == '0) n_eff = NW'(1);
		if (int'(n_eff) > MAX_SUBSPACES) n_eff = NW'(MAX_SUBSPACES);
		d_eff = 7'(sub_dim_q);
		if (d_eff == '0) d_eff = 7'd1;
		if (int'(d_eff) > MAX_SUB_DIM) d_eff = 7'(MAX_SUB_DIM);
	end

	assign euclid = (metric_q == pqltd_pkg::MET_EUCLID);

	// input unpack
	logic                 in_acc;
	pqltd_pkg::action_t   act;
	logic [4:0]           m_in;
	logic [7:0]           cent_in;
	logic [3:0]           comp_in;
	logic signed [VW-1:0] val_in;

	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign act     = pqltd_pkg::action_t'(s_axis_tuser);
	assign m_in    = s_axis_tdata[4:0];
	assign cent_in = s_axis_tdata[12:5];
	assign comp_in = s_axis_tdata[16:13];
	assign val_in  = s_axis_tdata[32:17];

	logic load_ok, query_ok, code_ok;

	assign load_ok  = (act == pqltd_pkg::ACT_LOAD) && (int'(m_in) < MAX_SUBSPACES)
		&& (int'(cent_in) < MAX_CENTROIDS) && (int'(comp_in) < MAX_SUB_DIM);
	assign query_ok = (act == pqltd_pkg::ACT_QUERY) && (7'(comp_in) < d_eff)
		&& (int'(m_in) < MAX_SUBSPACES);
	assign code_ok  = (act == pqltd_pkg::ACT_CODE) && (NW'(m_in) < n_eff);

	// centroid walk of a query
	logic                 walk_q;
	logic [CW-1:0]        cnt_q;
	logic [SW-1:0]        wm_q;
	logic [DW-1:0]        wcomp_q;
	logic signed [VW-1:0] wval_q;
	logic                 wfirst_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= 1'b0;
		end else if (in_acc && query_ok) begin
			walk_q <= 1'b1;
		end else if (walk_q && cnt_q == kmask) begin
			walk_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc && query_ok) begin
			cnt_q    <= '0;
			wm_q     <= SW'(m_in);
			wcomp_q  <= DW'(comp_in);
			wval_q   <= val_in;
			wfirst_q <= (comp_in == 4'd0);
		end else if (walk_q) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	// memories
	logic [VW-1:0]  cb_rd;
	logic [EW-1:0]  tb_rd;
	logic [TB_AW-1:0] tb_raddr;
	logic [CW-1:0]  code_idx;
	logic           tb_we;
	logic [EW-1:0]  tb_wdata;
	logic [CW-1:0]  qc_s1, qc_s2;
	logic           qv_s1, qv_s2;

	assign code_idx = CW'(cent_in) & kmask;
	assign tb_raddr = walk_q ? {wm_q, cnt_q} : {SW'(m_in), code_idx};

	pqltd_ram #(.WIDTH(VW), .AW(CB_AW)) u_cbook (
		.clk   (clk),
		.we    (in_acc && load_ok),
		.waddr ({SW'(m_in), CW'(cent_in), DW'(comp_in)}),
		.wdata (val_in),
		.raddr ({wm_q, cnt_q, wcomp_q}),
		.rdata (cb_rd)
	);

	pqltd_ram #(.WIDTH(EW), .AW(TB_AW)) u_table (
		.clk   (clk),
		.we    (tb_we),
		.waddr ({wm_q, qc_s2}),
		.wdata (tb_wdata),
		.raddr (tb_raddr),
		.rdata (tb_rd)
	);

	// query pipeline: s1 memory data and multiply, s2 accumulate and write back
	logic signed [VW:0]   mul_a, mul_b;
	logic signed [TW-1:0] term_s2;
	logic signed [EW-1:0] tb_s2;

	always_comb begin
		if (euclid) begin
			mul_a = (VW+1)'(wval_q) - (VW+1)'($signed(cb_rd));
			mul_b = mul_a;
		end else begin
			mul_a = (VW+1)'(wval_q);
			mul_b = -((VW+1)'($signed(cb_rd)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qv_s1 <= 1'b0;
			qv_s2 <= 1'b0;
		end else begin
			qv_s1 <= walk_q;
			qv_s2 <= qv_s1;
		end
	end

	always_ff @(posedge clk) begin
		qc_s1   <= cnt_q;
		qc_s2   <= qc_s1;
		term_s2 <= mul_a * mul_b;
		tb_s2   <= $signed(tb_rd);
	end

	assign tb_we    = qv_s2;
	assign tb_wdata = wfirst_q ? EW'(term_s2)
		: pqltd_pkg::sat_entry((EW+1)'(tb_s2) + (EW+1)'(term_s2));

	// code scan
	logic                  cv_s1, cfirst_s1, clast_s1;
	logic signed [SMW-1:0] score_q;
	logic signed [SMW-1:0] sum_s1;
	logic                  emit_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cv_s1 <= 1'b0;
		end else begin
			cv_s1 <= in_acc && code_ok;
		end
	end

	always_ff @(posedge clk) begin
		cfirst_s1 <= (m_in == 5'd0);
		clast_s1  <= (NW'(m_in) == n_eff - NW'(1));
	end

	assign sum_s1 = cfirst_s1 ? SMW'($signed(tb_rd))
		: pqltd_pkg::sat_sum((SMW+1)'(score_q) + (SMW+1)'($signed(tb_rd)));
	assign emit_s1 = cv_s1 && clast_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			score_q <= '0;
		end else if (cv_s1) begin
			score_q <= clast_s1 ? '0 : sum_s1;
		end
	end

	// euclidean root
	pqltd_pkg::sqrt_stat_t        sq;
	logic [pqltd_pkg::ROOT_W-1:0] root;

	pqltd_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (emit_s1 && euclid),
		.x      (sum_s1[SMW-1] ? '0 : sum_s1[SMW-2:0]),
		.stat   (sq),
		.root   (root)
	);

	// output register
	logic            out_valid_q;
	logic [SMW-1:0]  out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((emit_s1 && !euclid) || sq.done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sq.done) begin
			out_data_q <= SMW'(root);
		end else if (emit_s1) begin
			if (metric_q == pqltd_pkg::MET_COSINE)
				out_data_q <= pqltd_pkg::sat_sum((SMW+1)'(sum_s1) + ((SMW+1)'(1) <<< 24));
			else
				out_data_q <= sum_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {4'b0, out_data_q};

	// one item in flight for queries and emitting codes; the root's done cycle
	// still counts as busy since the result lands in the output register then
	assign s_axis_tready = !walk_q && !qv_s1 && !qv_s2 && !sq.busy && !sq.done
		&& !out_valid_q && !emit_s1;

	a_walk_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		walk_q |-> !out_valid_q) else $error("walk overlaps pending result");
	a_root_free: assert property (@(posedge clk) disable iff (!arst_n)
		sq.done |-> !out_valid_q) else $error("root done with output full");
	a_no_read_clash: assert property (@(posedge clk) disable iff (!arst_n)
		cv_s1 |-> !qv_s1 && !qv_s2) else $error("code read during table update");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !sq.busy && !walk_q) else $error("ready while busy");

endmodule

// ===== test/tb_pq_lookup_table_distance.sv =====
module tb_pq_lookup_table_distance;
	timeunit 1ns;
	timeprecision 1ps;

	// one input item as the predictor sees it
	typedef struct packed {
		pqltd_pkg::action_t act;
		logic [4:0]         sub;
		logic [7:0]         cent;
		logic [3:0]         comp;
		logic signed [15:0] val;
	} pq_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // subspace, centroid, component, value, pad
	logic [1:0]  s_axis_tuser = '0;   // action
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;        // distance, pad
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [5:0]  cfg_data = '0;

	pq_lookup_table_distance u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// shadow of the register file (raw written values)
	logic [1:0] sh_metric = 2'd0;
	logic [5:0] sh_count  = 6'd32;
	logic [3:0] sh_bits   = 4'd8;
	logic [4:0] sh_dim    = 5'd16;

	// shadow memories; key exists only once written
	logic signed [15:0] cb_mem  [int];
	logic signed [39:0] tbl_mem [int];
	longint             run_sum = 0;

	pq_item_t           pend_q [$];   // items waiting for the driver
	logic signed [43:0] dist_q [$];   // distances still to come out
	pq_item_t           drv_item;

	int  n_fail = 0;
	int  n_rand = 0;
	int  n_dist = 0;
	int  n_phase = 0;
	int  gap_cnt = 0;
	int  stall_cnt = 0;
	bit  quiet = 1'b0;
	bit  counting = 1'b0;

	function automatic int eff_k();
		int b = sh_bits;
		if (b < 4) b = 4;
		if (b > 8) b = 8;
		return 1 << b;
	endfunction

	function automatic int eff_cnt();
		int n = sh_count;
		if (n < 1) n = 1;
		if (n > 32) n = 32;
		return n;
	endfunction

	function automatic int eff_dim();
		int d = sh_dim;
		if (d < 1) d = 1;
		if (d > 16) d = 16;
		return d;
	endfunction

	function automatic longint clamp_bits(longint v, int bits);
		longint hi = (64'sd1 <<< (bits - 1)) - 1;
		if (v > hi) return hi;
		if (v < -hi - 1) return -hi - 1;
		return v;
	endfunction

	function automatic longint root_floor(longint unsigned x);
		longint unsigned res = 0;
		longint unsigned b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return longint'(res);
	endfunction

	// queue an item and advance the shadow state by it
	task automatic send_item(pqltd_pkg::action_t act, int sub, int cent, int comp, int val);
		pq_item_t it;
		int k, key, code;
		longint v, cbv, term, exp_d;
		it.act = act;
		it.sub = sub[4:0];
		it.cent = cent[7:0];
		it.comp = comp[3:0];
		it.val = val[15:0];
		pend_q.push_back(it);
		v = it.val;
		k = eff_k();
		if (counting && act != pqltd_pkg::ACT_NONE) n_rand++;
		case (act)
			pqltd_pkg::ACT_LOAD: begin
				cb_mem[{it.sub, it.cent, it.comp}] = it.val;
			end
			pqltd_pkg::ACT_QUERY: begin
				if (it.comp < eff_dim()) begin
					for (int c = 0; c < k; c++) begin
						key = {it.sub, c[7:0]};
						cbv = cb_mem[{it.sub, c[7:0], it.comp}];
						if (sh_metric == pqltd_pkg::MET_EUCLID)
							term = (v - cbv) * (v - cbv);
						else
							term = -(v * cbv);
						if (it.comp == 0)
							tbl_mem[key] = term;
						else
							tbl_mem[key] = clamp_bits(tbl_mem[key] + term, 40);
					end
				end
			end
			pqltd_pkg::ACT_CODE: begin
				if (it.sub < eff_cnt()) begin
					code = it.cent & (k - 1);
					key = {it.sub, code[7:0]};
					if (it.sub == 0)
						run_sum = clamp_bits(tbl_mem[key], 44);
					else
						run_sum = clamp_bits(run_sum + tbl_mem[key], 44);
					if (it.sub == eff_cnt() - 1) begin
						if (sh_metric == pqltd_pkg::MET_EUCLID)
							exp_d = (run_sum > 0) ? root_floor(run_sum) : 0;
						else if (sh_metric == pqltd_pkg::MET_COSINE)
							exp_d = clamp_bits((64'sd1 <<< 24) + run_sum, 44);
						else
							exp_d = run_sum;
						run_sum = 0;
						dist_q.push_back(exp_d[43:0]);
					end
				end
			end
			default: ;
		endcase
	endtask

	// input driver: one item per handshake, random idle bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			gap_cnt <= 0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (gap_cnt > 0) begin
				gap_cnt <= gap_cnt - 1;
				s_axis_tvalid <= 1'b0;
			end else if (pend_q.size() > 0) begin
				drv_item = pend_q.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= drv_item.act;
				s_axis_tdata <= {7'd0, drv_item.val, drv_item.comp, drv_item.cent, drv_item.sub};
				if (!quiet && $urandom_range(0, 11) == 0)
					gap_cnt <= $urandom_range(1, 9);
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// result side back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			stall_cnt <= 0;
		end else if (stall_cnt > 0) begin
			stall_cnt <= stall_cnt - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
			if (!quiet && $urandom_range(0, 5) == 0)
				stall_cnt <= $urandom_range(1, 9);
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (dist_q.size() == 0) begin
				$display("%0t: unexpected distance, expected none, actual %0d", $realtime,
					$signed(m_axis_tdata[43:0]));
				n_fail++;
			end else begin
				if (m_axis_tdata[43:0] !== dist_q[0]) begin
					$display("%0t: distance mismatch, expected %0d, actual %0d", $realtime,
						dist_q[0], $signed(m_axis_tdata[43:0]));
					n_fail++;
				end
				void'(dist_q.pop_front());
				n_dist++;
			end
		end
	end

	task automatic write_reg(pqltd_pkg::cfg_reg_t r, int d);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= r;
		cfg_data <= d[5:0];
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (r)
			pqltd_pkg::REG_METRIC:    sh_metric = d[1:0];
			pqltd_pkg::REG_SUB_COUNT: sh_count = d[5:0];
			pqltd_pkg::REG_CODE_BITS: sh_bits = d[3:0];
			default:                  sh_dim = d[4:0];
		endcase
	endtask

	// all items taken, all distances back, then let a query pass drain
	task automatic drain();
		do @(posedge clk); while (pend_q.size() != 0 || s_axis_tvalid || dist_q.size() != 0);
		repeat (300) @(posedge clk);
	endtask

	function automatic int rnd_val();
		int r = $urandom_range(0, 7);
		if (r == 0) return -32768;
		if (r == 1) return 32767;
		return $urandom_range(0, 65535) - 32768;
	endfunction

	task automatic code_run(int len);
		for (int m = 0; m < len; m++)
			send_item(pqltd_pkg::ACT_CODE, m, $urandom_range(0, 255), $urandom_range(0, 15),
				rnd_val());
	endtask

	task automatic fill_rows(int m, int nc);
		for (int c = 0; c < nc; c++)
			send_item(pqltd_pkg::ACT_QUERY, m, $urandom_range(0, 255), c, rnd_val());
	endtask

	// reconfigure, fill codebook and tables, then a mix of code runs and noise
	task automatic run_phase(int met, int cnt_raw, int bits_raw, int dim_raw, int nmix);
		int k, n, d, nl, r;
		drain();
		write_reg(pqltd_pkg::REG_METRIC, met);
		write_reg(pqltd_pkg::REG_SUB_COUNT, cnt_raw);
		write_reg(pqltd_pkg::REG_CODE_BITS, bits_raw);
		write_reg(pqltd_pkg::REG_SUB_DIM, dim_raw);
		n_phase++;
		k = eff_k();
		n = eff_cnt();
		d = eff_dim();
		// components actually filled; the rest are never queried
		nl = (n * k > 64) ? 1 : ((d < 3) ? d : 3);
		for (int m = 0; m < n; m++)
			for (int c = 0; c < k; c++)
				for (int p = 0; p < nl; p++)
					send_item(pqltd_pkg::ACT_LOAD, m, c, p, rnd_val());
		for (int m = 0; m < n; m++)
			fill_rows(m, nl);
		for (int i = 0; i < nmix; i++) begin
			r = $urandom_range(0, 9);
			if (r <= 5) begin
				code_run(n);
			end else if (r == 6) begin
				code_run($urandom_range(1, n));
			end else if (r == 7) begin
				if (n < 32 && $urandom_range(0, 1))
					send_item(pqltd_pkg::ACT_CODE, $urandom_range(n, 31),
						$urandom_range(0, 255), $urandom_range(0, 15), rnd_val());
				else
					send_item(pqltd_pkg::ACT_NONE, $urandom_range(0, 31),
						$urandom_range(0, 255), $urandom_range(0, 15), rnd_val());
			end else if (r == 8 && d < 16) begin
				send_item(pqltd_pkg::ACT_QUERY, $urandom_range(0, 31), $urandom_range(0, 255),
					$urandom_range(d, 15), rnd_val());
			end else begin
				// rewrite one codebook entry and rebuild that subspace's row
				r = $urandom_range(0, n - 1);
				send_item(pqltd_pkg::ACT_LOAD, r, $urandom_range(0, k - 1),
					$urandom_range(0, nl - 1), rnd_val());
				fill_rows(r, nl);
			end
		end
	endtask

	initial begin
		#20ms;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// directed: one subspace, one component, extreme values, ignored items
		write_reg(pqltd_pkg::REG_METRIC, pqltd_pkg::MET_EUCLID);
		write_reg(pqltd_pkg::REG_SUB_COUNT, 1);
		write_reg(pqltd_pkg::REG_CODE_BITS, 4);
		write_reg(pqltd_pkg::REG_SUB_DIM, 1);
		for (int c = 0; c < 16; c++)
			send_item(pqltd_pkg::ACT_LOAD, 0, c, 0,
				(c == 0) ? -32768 : (c == 1) ? 32767 : c * 4096);
		send_item(pqltd_pkg::ACT_QUERY, 0, 0, 0, 32767);
		send_item(pqltd_pkg::ACT_QUERY, 5, 0, 1, -32768);     // component beyond sub_dim
		send_item(pqltd_pkg::ACT_NONE, 31, 255, 15, -1);
		send_item(pqltd_pkg::ACT_CODE, 0, 8'hF0, 0, 0);       // masks to centroid 0
		send_item(pqltd_pkg::ACT_CODE, 31, 1, 0, 0);          // beyond subspace_count
		send_item(pqltd_pkg::ACT_CODE, 0, 1, 0, 0);
		drain();
		write_reg(pqltd_pkg::REG_METRIC, pqltd_pkg::MET_COSINE);
		send_item(pqltd_pkg::ACT_CODE, 0, 2, 0, 0);
		drain();
		write_reg(pqltd_pkg::REG_METRIC, pqltd_pkg::MET_DOT_X);
		send_item(pqltd_pkg::ACT_QUERY, 0, 0, 0, -32768);
		send_item(pqltd_pkg::ACT_CODE, 0, 1, 0, 0);

		counting = 1'b1;
		// extremes: all subspaces, widest rows, out-of-range register values
		run_phase(pqltd_pkg::MET_EUCLID, 63, 1, 20, 6);
		run_phase($urandom_range(0, 3), 0, 15, 0, 8);
		repeat (4)
			run_phase($urandom_range(0, 3),
				($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3),
				($urandom_range(0, 4) == 0) ? $urandom_range(0, 5) : 4,
				($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3), 20);
		// closing stretch at full rate
		drain();
		quiet = 1'b1;
		run_phase(pqltd_pkg::MET_COSINE, 2, 4, 2, 20);
		drain();

		$display("Covered %0d phases, %0d active random items, %0d distances checked",
			n_phase, n_rand, n_dist);
		$display("Metrics and register extremes cycled with random idle on both sides");
		if (n_fail == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
